[rtl/twrc_pkg.sv]
`default_nettype none

package twrc_pkg;

  // Widths fixed by the leg and result fields
  localparam int FIELD_BITS     = 24;
  localparam int COST_BITS      = 40;
  localparam int WEIGHT_BITS    = 8;
  localparam int CFG_INDEX_BITS = 8;

  // Default internal time width
  localparam int TIME_BITS_DEF = 24;

  // Packed stream widths
  localparam int S_TDATA_BITS = 4 * FIELD_BITS;
  localparam int M_TDATA_BITS = 3 * FIELD_BITS + COST_BITS;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LATE_WEIGHT = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WAIT_WEIGHT = CFG_INDEX_BITS'(1);

  // Weight reset values
  localparam logic [WEIGHT_BITS-1:0] LATE_WEIGHT_RST = WEIGHT_BITS'(1);
  localparam logic [WEIGHT_BITS-1:0] WAIT_WEIGHT_RST = WEIGHT_BITS'(1);

  // One route leg as taken from the input stream
  typedef struct packed {
    logic                  first_leg;
    logic [FIELD_BITS-1:0] start_time;
    logic [FIELD_BITS-1:0] travel_time;
    logic [FIELD_BITS-1:0] next_open;
    logic [FIELD_BITS-1:0] next_close;
    logic                  last_leg;
  } leg_t;

endpackage

`default_nettype wire

[rtl/twrc_in_reg.sv]
`default_nettype none

module twrc_in_reg
  import twrc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [S_TDATA_BITS-1:0] in_data,
  input  wire logic                    in_user,
  input  wire logic                    in_last,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output leg_t                         leg
);

  // Take a new request when empty or when the held one moves on
  assign in_ready = !out_valid || out_ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Unpack and hold the leg
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      leg.first_leg   <= in_user;
      leg.start_time  <= in_data[FIELD_BITS-1:0];
      leg.travel_time <= in_data[2*FIELD_BITS-1:FIELD_BITS];
      leg.next_open   <= in_data[3*FIELD_BITS-1:2*FIELD_BITS];
      leg.next_close  <= in_data[4*FIELD_BITS-1:3*FIELD_BITS];
      leg.last_leg    <= in_last;
    end
  end

endmodule

`default_nettype wire

[rtl/twrc_time_stage.sv]
`default_nettype none

module twrc_time_stage
  import twrc_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire leg_t                 leg,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      first_leg,
  output logic                      last_leg,
  output logic [TIME_BITS-1:0]      travel,
  output logic [TIME_BITS-1:0]      arrival,
  output logic [TIME_BITS-1:0]      wait_time,
  output logic [TIME_BITS-1:0]      lateness
);

  localparam int EXT_BITS = (TIME_BITS > FIELD_BITS) ? TIME_BITS : FIELD_BITS;
  localparam logic [EXT_BITS-1:0] TIME_MAX_EXT = EXT_BITS'({TIME_BITS{1'b1}});

  // Saturate a field value to the internal time range
  function automatic logic [TIME_BITS-1:0] clamp_time(input logic [FIELD_BITS-1:0] v);
    logic [EXT_BITS-1:0] e;
    e = EXT_BITS'(v);
    if (e > TIME_MAX_EXT) e = TIME_MAX_EXT;
    return e[TIME_BITS-1:0];
  endfunction

  logic [TIME_BITS-1:0] departure;
  logic [TIME_BITS-1:0] departure_next;
  logic [TIME_BITS-1:0] start_c;
  logic [TIME_BITS-1:0] travel_c;
  logic [TIME_BITS-1:0] open_c;
  logic [TIME_BITS-1:0] close_c;
  logic [TIME_BITS-1:0] dep_base;
  logic [TIME_BITS:0]   arr_sum;
  logic [TIME_BITS-1:0] arrive_c;
  logic [TIME_BITS-1:0] wait_c;
  logic [TIME_BITS-1:0] late_c;
  logic                 load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  // Arrival, wait and lateness for the held leg
  always_comb begin
    start_c  = clamp_time(leg.start_time);
    travel_c = clamp_time(leg.travel_time);
    open_c   = clamp_time(leg.next_open);
    close_c  = clamp_time(leg.next_close);
    dep_base = leg.first_leg ? start_c : departure;
    arr_sum  = {1'b0, dep_base} + {1'b0, travel_c};
    arrive_c = arr_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : arr_sum[TIME_BITS-1:0];
    wait_c   = (open_c > arrive_c) ? open_c - arrive_c : '0;
    late_c   = (arrive_c > close_c) ? arrive_c - close_c : '0;
    // arrival plus wait is the later of arrival and opening
    departure_next = (arrive_c > open_c) ? arrive_c : open_c;
  end

  // Advance the departure time and stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      departure <= '0;
    end else begin
      if (in_ready) out_valid <= in_valid;
      if (load) departure <= departure_next;
    end
  end

  // Hold leg results for the cost stage
  always_ff @(posedge clk) begin
    if (load) begin
      first_leg <= leg.first_leg;
      last_leg  <= leg.last_leg;
      travel    <= travel_c;
      arrival   <= arrive_c;
      wait_time <= wait_c;
      lateness  <= late_c;
    end
  end

endmodule

`default_nettype wire

[rtl/twrc_cost_stage.sv]
`default_nettype none

module twrc_cost_stage
  import twrc_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    first_leg,
  input  wire logic                    last_leg,
  input  wire logic [TIME_BITS-1:0]    travel,
  input  wire logic [TIME_BITS-1:0]    arrival,
  input  wire logic [TIME_BITS-1:0]    wait_time,
  input  wire logic [TIME_BITS-1:0]    lateness,
  input  wire logic [WEIGHT_BITS-1:0]  late_weight,
  input  wire logic [WEIGHT_BITS-1:0]  wait_weight,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [M_TDATA_BITS-1:0]      out_data,
  output logic                         out_last
);

  localparam int PROD_BITS = TIME_BITS + WEIGHT_BITS;
  localparam int SUM_BITS  = ((PROD_BITS + 2 > COST_BITS) ? PROD_BITS + 2 : COST_BITS) + 1;
  localparam int EXT_BITS  = (TIME_BITS > FIELD_BITS) ? TIME_BITS : FIELD_BITS;
  localparam logic [SUM_BITS-1:0] COST_MAX_EXT = SUM_BITS'({COST_BITS{1'b1}});

  // Fit an internal time to its output field
  function automatic logic [FIELD_BITS-1:0] to_field(input logic [TIME_BITS-1:0] v);
    logic [EXT_BITS-1:0] e;
    e = EXT_BITS'(v);
    return e[FIELD_BITS-1:0];
  endfunction

  logic [COST_BITS-1:0]  cost_total;
  logic [COST_BITS-1:0]  cost_base;
  logic [PROD_BITS-1:0]  late_prod;
  logic [PROD_BITS-1:0]  wait_prod;
  logic [SUM_BITS-1:0]   cost_sum;
  logic [COST_BITS-1:0]  cost_total_next;
  logic [FIELD_BITS-1:0] arrival_q;
  logic [FIELD_BITS-1:0] wait_q;
  logic [FIELD_BITS-1:0] late_q;
  logic                  load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  // Weighted penalties and saturating running cost
  always_comb begin
    cost_base = first_leg ? '0 : cost_total;
    late_prod = PROD_BITS'(lateness) * PROD_BITS'(late_weight);
    wait_prod = PROD_BITS'(wait_time) * PROD_BITS'(wait_weight);
    cost_sum  = SUM_BITS'(cost_base) + SUM_BITS'(travel)
              + SUM_BITS'(late_prod) + SUM_BITS'(wait_prod);
    cost_total_next = (cost_sum > COST_MAX_EXT) ? {COST_BITS{1'b1}}
                                                : cost_sum[COST_BITS-1:0];
  end

  // Advance the running cost and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      cost_total <= '0;
    end else begin
      if (in_ready) out_valid <= in_valid;
      if (load) cost_total <= cost_total_next;
    end
  end

  // Hold the result fields
  always_ff @(posedge clk) begin
    if (load) begin
      arrival_q <= to_field(arrival);
      wait_q    <= to_field(wait_time);
      late_q    <= to_field(lateness);
      out_last  <= last_leg;
    end
  end

  assign out_data = {cost_total, late_q, wait_q, arrival_q};

endmodule

`default_nettype wire

[rtl/time_window_route_cost_top.sv]
// A leg passes the input register, then the time and cost stage registers,
// before its result shows on m_axis_tvalid. Throughput: one leg per cycle
// unless m_axis_tready stalls; the departure feedback (one saturating add and
// one compare in the time stage) and the cost feedback each close on a register.
// Reset (synchronous, rst high) empties all stages, sets both weights to 1
// and clears departure time and running cost to zero.
`default_nettype none

module time_window_route_cost_top
  import twrc_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // tdata: start_time, travel_time, next_open, next_close
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [S_TDATA_BITS-1:0]   s_axis_tdata,
  // tuser: first_leg
  input  wire logic                      s_axis_tuser,
  // tlast: last_leg
  input  wire logic                      s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // tdata: arrival, wait_time, lateness, total_cost
  output logic [M_TDATA_BITS-1:0]        m_axis_tdata,
  // tlast: route_done
  output logic                           m_axis_tlast,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [WEIGHT_BITS-1:0]    cfg_data
);

  leg_t                 leg;
  logic                 leg_valid;
  logic                 leg_ready;
  logic                 time_valid;
  logic                 time_ready;
  logic                 t_first;
  logic                 t_last;
  logic [TIME_BITS-1:0] t_travel;
  logic [TIME_BITS-1:0] t_arrival;
  logic [TIME_BITS-1:0] t_wait;
  logic [TIME_BITS-1:0] t_late;
  logic [WEIGHT_BITS-1:0] late_weight;
  logic [WEIGHT_BITS-1:0] wait_weight;

  assign cfg_ready = 1'b1;

  // Write weight registers, drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      late_weight <= LATE_WEIGHT_RST;
      wait_weight <= WAIT_WEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LATE_WEIGHT: late_weight <= cfg_data;
        CFG_WAIT_WEIGHT: wait_weight <= cfg_data;
        default: ;
      endcase
    end
  end

  twrc_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .in_last   (s_axis_tlast),
    .out_valid (leg_valid),
    .out_ready (leg_ready),
    .leg       (leg)
  );

  twrc_time_stage #(.TIME_BITS(TIME_BITS)) u_time (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (leg_valid),
    .in_ready  (leg_ready),
    .leg       (leg),
    .out_valid (time_valid),
    .out_ready (time_ready),
    .first_leg (t_first),
    .last_leg  (t_last),
    .travel    (t_travel),
    .arrival   (t_arrival),
    .wait_time (t_wait),
    .lateness  (t_late)
  );

  twrc_cost_stage #(.TIME_BITS(TIME_BITS)) u_cost (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (time_valid),
    .in_ready    (time_ready),
    .first_leg   (t_first),
    .last_leg    (t_last),
    .travel      (t_travel),
    .arrival     (t_arrival),
    .wait_time   (t_wait),
    .lateness    (t_late),
    .late_weight (late_weight),
    .wait_weight (wait_weight),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata),
    .out_last    (m_axis_tlast)
  );

endmodule

`default_nettype wire

[rtl/twrc_checker.sv]
`default_nettype none

module twrc_checker
  import twrc_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      s_axis_tready,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [M_TDATA_BITS-1:0]   m_axis_tdata,
  input wire logic                      m_axis_tlast
);

  // A stalled result stays offered
  a_out_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result payload changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result offered right after reset");

  // With no result waiting, the input side must take requests
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind time_window_route_cost_top twrc_checker u_twrc_checker (.*);

`default_nettype wire
